@@ src/fbflg_pkg.sv @@
package fbflg_pkg;

   // delay line
   localparam int BUFFER_SIZE = 4096;
   localparam int ADDR_W      = $clog2(BUFFER_SIZE);
   localparam int FRAC_W      = 8;
   localparam int POS_W       = ADDR_W + FRAC_W;
   localparam int DELAY_W     = POS_W + 2;
   localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'((BUFFER_SIZE - 1) * (1 << FRAC_W));
   localparam logic [FRAC_W:0]    FRAC_ONE  = (FRAC_W + 1)'(1 << FRAC_W);

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int DEPTH_W  = 11;
   localparam int PCT_W    = 7;
   localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

   // shared multiplier
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // quarter wave sine polynomial, Q16
   localparam logic [16:0] SIN_A    = 17'd102944;
   localparam logic [16:0] SIN_B    = 17'd42334;
   localparam logic [16:0] SIN_C    = 17'd4926;
   localparam logic [16:0] SIN_ONE  = 17'd65536;
   localparam logic [15:0] SIN_MAX  = 16'd32767;
   localparam logic [15:0] SIN_HALF = 16'd32768;

   // feedback scaling: floor(p / 100) done on p + 100 * 2^23 as
   // (n * 0x51EB851F) >> 37, the reciprocal split in two 16-bit halves
   localparam int DIV_W     = 31;
   localparam int QUOT_W    = SAMPLE_W;
   localparam int RCP_LO_W  = 31;
   localparam int RCP_SUM_W = 45;
   localparam logic [16:0] RCP100_HI = 17'h051EB;
   localparam logic [16:0] RCP100_LO = 17'h0851F;
   localparam logic [31:0] FB_BIAS   = 32'd838860800;

   // lfo phase step per rate setting
   localparam int SAMPLE_RATE  = 48000;
   localparam int RATE_ENTRIES = 1 << PCT_W;
   localparam int RATE_BASE    = 100;
   localparam int RATE_SLOPE   = 99;
   localparam logic [63:0] STEP_DIV = 64'(1000) * 64'(SAMPLE_RATE);

   typedef logic [RATE_ENTRIES-1:0][31:0] step_table_type;

   function automatic step_table_type build_step_table();
      step_table_type t;
      logic [63:0]    num;
      for (int i = 0; i < RATE_ENTRIES; i++) begin
         num  = 64'(RATE_BASE + RATE_SLOPE * i) << 32;
         t[i] = 32'(num / STEP_DIV);
      end
      return t;
   endfunction

   localparam step_table_type STEP_TABLE = build_step_table();

   // configuration
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_DEPTH_SAMPLES    = 2'd0,
      REG_RATE_PERCENT     = 2'd1,
      REG_PREDELAY_SAMPLES = 2'd2,
      REG_FEEDBACK_PERCENT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_samples;
      logic [PCT_W-1:0]   rate_percent;
      logic [DEPTH_W-1:0] predelay_samples;
      logic [PCT_W-1:0]   feedback_percent;
   } cfg_type;

endpackage

@@ src/fbflg_csr.sv @@
module fbflg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fbflg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fbflg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fbflg_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output fbflg_pkg::cfg_type                  cfg
);
   import fbflg_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;

   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (index)
            REG_DEPTH_SAMPLES:    cfg_in.depth_samples    = pwdata[DEPTH_W-1:0];
            REG_RATE_PERCENT:     cfg_in.rate_percent     = pwdata[PCT_W-1:0];
            REG_PREDELAY_SAMPLES: cfg_in.predelay_samples = pwdata[DEPTH_W-1:0];
            REG_FEEDBACK_PERCENT: cfg_in.feedback_percent = pwdata[PCT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_DEPTH_SAMPLES:    prdata = CSR_DATA_W'(cfg_ff.depth_samples);
         REG_RATE_PERCENT:     prdata = CSR_DATA_W'(cfg_ff.rate_percent);
         REG_PREDELAY_SAMPLES: prdata = CSR_DATA_W'(cfg_ff.predelay_samples);
         REG_FEEDBACK_PERCENT: prdata = CSR_DATA_W'(cfg_ff.feedback_percent);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/fbflg_mul.sv @@
module fbflg_mul (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [fbflg_pkg::MUL_A_W-1:0]    a,
   input  logic signed [fbflg_pkg::MUL_B_W-1:0]    b,
   output logic signed [fbflg_pkg::MUL_P_W-1:0]    prod
);
   import fbflg_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff, prod_in;

   assign prod_in = MUL_P_W'(a) * MUL_P_W'(b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

@@ src/fbflg_div.sv @@
module fbflg_div (
   input  logic                                    clock,
   input  logic                                    keep_lo,
   input  logic signed [fbflg_pkg::MUL_P_W-1:0]    prod,
   output logic [fbflg_pkg::QUOT_W-1:0]            quot
);
   import fbflg_pkg::*;

   logic [RCP_LO_W-1:0]  lo_ff, lo_in;
   logic [RCP_SUM_W-1:0] sum;

   // n * low half arrives first and is kept shifted down by 16,
   // then n * high half is added; the quotient is below 2^24 so the sum fits
   assign lo_in = prod[46:16];
   assign sum   = prod[RCP_SUM_W-1:0] + RCP_SUM_W'(lo_ff);
   assign quot  = sum[44:21];

   always_ff @(posedge clock) begin
      if (keep_lo) begin
         lo_ff <= lo_in;
      end
   end

endmodule

@@ src/fbflg_mem.sv @@
module fbflg_mem (
   input  logic                                clock,
   input  logic                                we,
   input  logic [fbflg_pkg::ADDR_W-1:0]        waddr,
   input  logic [fbflg_pkg::SAMPLE_W-1:0]      wdata,
   input  logic [fbflg_pkg::ADDR_W-1:0]        raddr,
   output logic [fbflg_pkg::SAMPLE_W-1:0]      rdata
);
   import fbflg_pkg::*;

   logic [SAMPLE_W-1:0] line_ff [BUFFER_SIZE];
   logic [SAMPLE_W-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         line_ff[waddr] <= wdata;
      end
      rdata_ff <= line_ff[raddr];
   end

endmodule

@@ src/feedback_flanger.sv @@
// channel  direction  handshake                     payload
// req      in         req_valid / req_ready         req_dry_sample   (s24, Q1.23)
// rsp      out        rsp_valid / rsp_ready         rsp_wet_sample   (s24, Q1.23)
// csr      in         csr_psel / csr_penable        csr_paddr, csr_pwdata, csr_prdata
//
// after the accept, each item steps through 15 sequencer states, ten of them
// passes through the shared 32x18 multiplier; the divide by 100 of the feedback
// is a reciprocal multiply in two of those passes.
// req_ready is high only while idle; a finished item waits in the rsp register
// and the next item is taken meanwhile, stalling before its write-back.
// reset clears control, config, the lfo phase and the write pointer; the delay
// line itself is not cleared, entries not yet written since reset read as zero.
module feedback_flanger (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [fbflg_pkg::SAMPLE_W-1:0]  req_dry_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [fbflg_pkg::SAMPLE_W-1:0]  rsp_wet_sample,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [fbflg_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [fbflg_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [fbflg_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);
   import fbflg_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_ZSQ   = 16'h0002,
      S_ZC    = 16'h0004,
      S_INNER = 16'h0008,
      S_OUTER = 16'h0010,
      S_SINE  = 16'h0020,
      S_DEPTH = 16'h0040,
      S_DELAY = 16'h0080,
      S_RD0   = 16'h0100,
      S_RD1   = 16'h0200,
      S_X1    = 16'h0400,
      S_SUM   = 16'h0800,
      S_FB    = 16'h1000,
      S_RCPLO = 16'h2000,
      S_RCPHI = 16'h4000,
      S_DONE  = 16'h8000
   } state_type;

   cfg_type cfg;

   state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0] dry_ff, dry_in;
   logic signed [SAMPLE_W-1:0] wet_ff, wet_in;
   logic signed [SAMPLE_W-1:0] out_ff, out_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]          wi_ff, wi_in;
   logic                       wrapped_ff, wrapped_in;
   logic [31:0]                phase_ff, phase_in;
   logic [16:0]                z2_ff, z2_in;
   logic [15:0]                sine_ofs_ff, sine_ofs_in;
   logic [DELAY_W-1:0]         delay_ff, delay_in;
   logic [ADDR_W-1:0]          idx1_ff, idx1_in;
   logic [FRAC_W-1:0]          frac_ff, frac_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic signed [32:0]         acc0_ff, acc0_in;
   logic [DIV_W-1:0]           rcp_num_ff, rcp_num_in;

   // shared multiplier
   logic                       mul_en;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  prod;

   // divide by 100
   logic                       div_keep_lo;
   logic [DIV_W-1:0]           div_num;
   logic [QUOT_W-1:0]          div_quot;

   // delay line
   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_raddr;
   logic [SAMPLE_W-1:0]        mem_rdata;
   logic [SAMPLE_W-1:0]        mem_wdata;

   // datapath helpers
   logic [PCT_W-1:0]           rate_sat, fb_sat;
   logic [1:0]                 quad;
   logic [16:0]                z;
   logic [16:0]                inner, outer;
   logic [15:0]                s_raw, s_cap;
   logic [DELAY_W-1:0]         delay_sum;
   logic [POS_W-1:0]           pos;
   logic signed [SAMPLE_W-1:0] tap;
   logic signed [32:0]         acc;
   logic signed [SAMPLE_W-1:0] fb_term;
   logic signed [SAMPLE_W:0]   wr_sum;
   logic signed [SAMPLE_W-1:0] wr_sat;

   fbflg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   fbflg_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   fbflg_div u_div (
      .clock   (clock),
      .keep_lo (div_keep_lo),
      .prod    (prod),
      .quot    (div_quot)
   );

   fbflg_mem u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (wi_ff),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wet_sample = out_ff;

   assign rate_sat = (cfg.rate_percent > PCT_MAX) ? PCT_MAX : cfg.rate_percent;
   assign fb_sat   = (cfg.feedback_percent > PCT_MAX) ? PCT_MAX : cfg.feedback_percent;

   // position inside the quadrant, mirrored in odd quadrants
   assign quad = phase_ff[31:30];
   assign z    = quad[0] ? (SIN_ONE - {1'b0, phase_ff[29:14]}) : {1'b0, phase_ff[29:14]};

   assign inner = SIN_B - {4'b0, prod[28:16]};
   assign outer = SIN_A - {1'b0, prod[31:16]};
   assign s_raw = prod[32:17];
   assign s_cap = (s_raw > SIN_MAX) ? SIN_MAX : s_raw;

   assign delay_sum = DELAY_W'({cfg.depth_samples, 7'b0}) + DELAY_W'(prod[26:8])
                    + DELAY_W'({cfg.predelay_samples, 8'b0});
   assign pos       = {wi_ff, {FRAC_W{1'b0}}} - delay_ff[POS_W-1:0];

   // entries not yet written since reset read as zero
   assign tap = rd_valid_ff ? $signed(mem_rdata) : '0;
   assign acc = acc0_ff + $signed(prod[32:0]);

   // quotient minus 2^23 removes the bias
   assign fb_term = $signed({~div_quot[QUOT_W-1], div_quot[QUOT_W-2:0]});
   assign wr_sum  = (SAMPLE_W + 1)'(dry_ff) + (SAMPLE_W + 1)'(fb_term);
   always_comb begin
      if (wr_sum[SAMPLE_W] != wr_sum[SAMPLE_W-1]) begin
         wr_sat = wr_sum[SAMPLE_W] ? $signed({1'b1, {(SAMPLE_W-1){1'b0}}})
                                   : $signed({1'b0, {(SAMPLE_W-1){1'b1}}});
      end else begin
         wr_sat = wr_sum[SAMPLE_W-1:0];
      end
   end
   assign mem_wdata = wr_sat;

   assign rd_valid_in = wrapped_ff || (mem_raddr < wi_ff);
   assign div_num     = DIV_W'(prod[31:0] + FB_BIAS);

   always_comb begin
      state_in     = state_ff;
      dry_in       = dry_ff;
      wet_in       = wet_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      wi_in        = wi_ff;
      wrapped_in   = wrapped_ff;
      phase_in     = phase_ff;
      z2_in        = z2_ff;
      sine_ofs_in  = sine_ofs_ff;
      delay_in     = delay_ff;
      idx1_in      = idx1_ff;
      frac_in      = frac_ff;
      acc0_in      = acc0_ff;
      rcp_num_in   = rcp_num_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_keep_lo  = 1'b0;
      mem_we       = 1'b0;
      mem_raddr    = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dry_in   = req_dry_sample;
               state_in = S_ZSQ;
            end
         end
         S_ZSQ: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(z);
            mul_b    = MUL_B_W'(z);
            state_in = S_ZC;
         end
         S_ZC: begin
            z2_in    = prod[32:16];
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(prod[32:16]);
            mul_b    = MUL_B_W'(SIN_C);
            state_in = S_INNER;
         end
         S_INNER: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(z2_ff);
            mul_b    = MUL_B_W'(inner);
            state_in = S_OUTER;
         end
         S_OUTER: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(outer);
            mul_b    = MUL_B_W'(z);
            state_in = S_SINE;
         end
         S_SINE: begin
            // sine + 32768, negative half in quadrants 2 and 3
            sine_ofs_in = quad[1] ? (SIN_HALF - s_cap) : (SIN_HALF + s_cap);
            state_in    = S_DEPTH;
         end
         S_DEPTH: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(sine_ofs_ff);
            mul_b    = MUL_B_W'(cfg.depth_samples);
            state_in = S_DELAY;
         end
         S_DELAY: begin
            delay_in = (delay_sum > DELAY_MAX) ? DELAY_MAX : delay_sum;
            state_in = S_RD0;
         end
         S_RD0: begin
            mem_raddr = pos[POS_W-1:FRAC_W];
            idx1_in   = pos[POS_W-1:FRAC_W] + 1'b1;
            frac_in   = pos[FRAC_W-1:0];
            state_in  = S_RD1;
         end
         S_RD1: begin
            mem_raddr = idx1_ff;
            mul_en    = 1'b1;
            mul_a     = MUL_A_W'(tap);
            mul_b     = MUL_B_W'(FRAC_ONE - {1'b0, frac_ff});
            state_in  = S_X1;
         end
         S_X1: begin
            acc0_in  = $signed(prod[32:0]);
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(tap);
            mul_b    = MUL_B_W'(frac_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            wet_in   = acc[31:8];
            state_in = S_FB;
         end
         S_FB: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(wet_ff);
            mul_b    = MUL_B_W'(fb_sat);
            state_in = S_RCPLO;
         end
         S_RCPLO: begin
            // biased product times the low half of the reciprocal
            rcp_num_in = div_num;
            mul_en     = 1'b1;
            mul_a      = MUL_A_W'(div_num);
            mul_b      = MUL_B_W'(RCP100_LO);
            state_in   = S_RCPHI;
         end
         S_RCPHI: begin
            div_keep_lo = 1'b1;
            mul_en      = 1'b1;
            mul_a       = MUL_A_W'(rcp_num_ff);
            mul_b       = MUL_B_W'(RCP100_HI);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               out_in       = wet_ff;
               wi_in        = wi_ff + 1'b1;
               if (wi_ff == '1) begin
                  wrapped_in = 1'b1;
               end
               phase_in = phase_ff + STEP_TABLE[rate_sat];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wi_ff        <= '0;
         wrapped_ff   <= 1'b0;
         phase_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wi_ff        <= wi_in;
         wrapped_ff   <= wrapped_in;
         phase_ff     <= phase_in;
      end
      dry_ff      <= dry_in;
      wet_ff      <= wet_in;
      out_ff      <= out_in;
      z2_ff       <= z2_in;
      sine_ofs_ff <= sine_ofs_in;
      delay_ff    <= delay_in;
      idx1_ff     <= idx1_in;
      frac_ff     <= frac_in;
      rd_valid_ff <= rd_valid_in;
      acc0_ff     <= acc0_in;
      rcp_num_ff  <= rcp_num_in;
   end

endmodule
